// ===== design/cprr_pkg.sv =====
// Shared types and constants of the credit priority round-robin scheduler.
`timescale 1ns / 1ps
`default_nettype none
package cprr_pkg;
  localparam int NSLOT  = 8;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 4;
  localparam logic [7:0] CREDIT_NEVER = 8'd255;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_URGENT = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SLOT_COUNT = 2'd0,
    REG_QUANTUM    = 2'd1,
    REG_PRIO       = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SCAN,
    ST_APPLY,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              load_prio;
    logic              run_we;
    logic              run_val;
    logic              urg_set;
    logic              urg_clr;
    logic [SLOT_W-1:0] tgt;
    logic              apply;
    logic [SLOT_W-1:0] best;
    logic [7:0]        low;
    logic [CNT_W-1:0]  ring_n;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== design/cprr_cell.sv =====
// One scheduler slot cell: credit, urgent flag, run state and selection count.
`timescale 1ns / 1ps
`default_nettype none
module cprr_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [cprr_pkg::SLOT_W-1:0] cell_id,
  input  wire logic [7:0]               prio,
  input  wire cprr_pkg::cell_ctl_t      ctl,
  output logic [7:0]                    credit,
  output logic                          urgent,
  output logic                          run,
  output logic [31:0]                   count
);
  import cprr_pkg::*;

  logic [7:0]  credit_r, credit_nxt;
  logic        urgent_r, urgent_nxt;
  logic        run_r, run_nxt;
  logic [31:0] count_r, count_nxt;
  logic        hit, in_ring;

  assign hit     = (ctl.tgt == cell_id);
  assign in_ring = ({1'b0, cell_id} < ctl.ring_n);

  always_comb begin
    credit_nxt = credit_r;
    urgent_nxt = urgent_r;
    run_nxt    = run_r;
    count_nxt  = count_r;
    if (ctl.load_prio) credit_nxt = prio;
    if (ctl.run_we && hit) run_nxt = ctl.run_val;
    if (ctl.urg_set && hit) urgent_nxt = 1'b1;
    if (ctl.urg_clr && hit) begin
      urgent_nxt = 1'b0;
      count_nxt  = count_r + 32'd1;
    end
    if (ctl.apply) begin
      if (ctl.best == cell_id) begin
        credit_nxt = prio;
        count_nxt  = count_r + 32'd1;
      end else if (in_ring && run_r) begin
        credit_nxt = credit_r - ctl.low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      urgent_r <= 1'b0;
      run_r    <= 1'b0;
      count_r  <= '0;
    end else begin
      credit_r <= credit_nxt;
      urgent_r <= urgent_nxt;
      run_r    <= run_nxt;
      count_r  <= count_nxt;
    end
  end

  assign credit = credit_r;
  assign urgent = urgent_r;
  assign run    = run_r;
  assign count  = count_r;
endmodule
`default_nettype wire

// ===== design/credit_priority_round_robin_scheduler_unit.sv =====
// Top level of the credit priority round-robin scheduler.
//
// Usage: each input transfer carries a command (tick, urgent request for a
// slot, or run state change) and yields exactly one result transfer with the
// executing slot, a valid flag, a switched flag, the pending urgent count and
// the selection count of the executing slot.
// Slot state lives in a row of eight slot cells; a sequencer walks the ring
// one position per cycle, reading one cell each cycle and carrying the best
// candidate forward; a credit pick then broadcasts its credit update to all cells.
// Steps: urgent request, run state and non-scheduling tick items go straight
// to the result register; a scheduling tick on an empty ring passes through
// the finish state first. Otherwise a tick normalizes the ring head, scans
// the ring, applies the credit update for a credit pick, then finishes; an
// urgent pick ends the scan early at the urgent slot. One item is in work at
// a time.
// The input is taken again as soon as the result is parked in the output
// register, so the next item can be in work while the result waits.
// Reset (synchronous, rst_n low): all slots blocked, no urgent flags, counts
// and credits zero, no slot selected, registers at their reset values.
// Receiver stall: a finished result waits in the output register; a second
// finished result holds the sequencer until the first one is taken.
// Configuration: APB-style, 64-bit data; slot_count at 0x0, quantum_ticks at
// 0x8, slot_priorities at 0x10. Writing priorities reloads every credit.
`timescale 1ns / 1ps
`default_nettype none
module credit_priority_round_robin_scheduler_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [2:0]  in_slot,
  input  wire logic        in_running,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_executing_slot,
  output logic             out_executing_valid,
  output logic             out_switched,
  output logic [3:0]       out_pending_count,
  output logic [31:0]      out_selected_runs,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import cprr_pkg::*;

  // configuration registers
  logic [3:0]  slot_count_r;
  logic [15:0] quantum_r;
  logic [63:0] prio_r;
  logic [63:0] prio_w;
  logic        cfg_we;
  reg_idx_t    cfg_idx;

  // sequencer state
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [15:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0]  pending_r, pending_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic              got_r, got_nxt;
  logic [SLOT_W-1:0] win_r, win_nxt;
  logic              found_r, found_nxt;
  logic [7:0]        low_r, low_nxt;
  logic [SLOT_W-1:0] best_r, best_nxt;
  logic              sw_r, sw_nxt;

  // result register
  logic              out_valid_r;
  logic [2:0]        o_slot_r;
  logic              o_valid_r, o_sw_r;
  logic [3:0]        o_pend_r;
  logic [31:0]       o_runs_r;
  logic              out_load;

  cell_ctl_t         ctl;
  logic [CNT_W-1:0]  ring_n;
  logic [7:0]        credit_w [NSLOT];
  logic              urgent_w [NSLOT];
  logic              run_w    [NSLOT];
  logic [31:0]       count_w  [NSLOT];

  logic [CNT_W-1:0]  s_sum, s_wrap, s_inc;
  logic [SLOT_W-1:0] s_idx;
  logic              blocked, sched, take;
  logic [16:0]       phase_inc;
  logic [15:0]       q_eff;
  cmd_t              cmd;

  // Configuration port: write on the access phase, read back any register.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);

  always_comb begin
    case (cfg_idx)
      REG_SLOT_COUNT: prdata = {60'd0, slot_count_r};
      REG_QUANTUM:    prdata = {48'd0, quantum_r};
      REG_PRIO:       prdata = prio_r;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= '0;
      quantum_r    <= 16'd10;
      prio_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SLOT_COUNT: slot_count_r <= pwdata[3:0];
        REG_QUANTUM:    quantum_r    <= pwdata[15:0];
        REG_PRIO:       prio_r       <= pwdata;
        default:        ;
      endcase
    end
  end

  // Hand the cells the new priorities in the write cycle so the reload sees them.
  assign prio_w = (cfg_we && cfg_idx == REG_PRIO) ? pwdata : prio_r;

  // Ring length clamps to the number of cells.
  assign ring_n = (slot_count_r > CNT_W'(NSLOT)) ? CNT_W'(NSLOT) : slot_count_r;

  // Slot cells
  for (genvar g = 0; g < NSLOT; g++) begin : g_cell
    cprr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_id(SLOT_W'(g)),
      .prio   (prio_w[8*g +: 8]),
      .ctl    (ctl),
      .credit (credit_w[g]),
      .urgent (urgent_w[g]),
      .run    (run_w[g]),
      .count  (count_w[g])
    );
  end

  // Ring position to slot: head and pos are both below n, so one subtract wraps.
  assign s_sum  = {1'b0, head_r} + {1'b0, pos_r};
  assign s_wrap = (s_sum >= ring_n) ? s_sum - ring_n : s_sum;
  assign s_idx  = s_wrap[SLOT_W-1:0];
  assign s_inc  = (s_wrap + CNT_W'(1) == ring_n) ? '0 : s_wrap + CNT_W'(1);

  assign cmd       = cmd_t'(in_command);
  assign blocked   = cur_valid_r && !run_w[cur_r];
  assign sched     = (phase_r == '0) || (pending_r != '0) || blocked;
  assign q_eff     = (quantum_r == '0) ? 16'd1 : quantum_r;
  assign phase_inc = {1'b0, phase_r} + 17'd1;
  assign take      = run_w[s_idx] && (credit_w[s_idx] < low_r);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    pending_nxt   = pending_r;
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    got_nxt       = got_r;
    win_nxt       = win_r;
    found_nxt     = found_r;
    low_nxt       = low_r;
    best_nxt      = best_r;
    sw_nxt        = sw_r;
    ctl           = '0;
    ctl.ring_n    = ring_n;
    ctl.best      = best_r;
    ctl.low       = low_r;
    ctl.load_prio = cfg_we && (cfg_idx == REG_PRIO);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sw_nxt    = 1'b0;
          state_nxt = ST_DONE;
          ctl.tgt   = in_slot;
          case (cmd)
            CMD_TICK: begin
              phase_nxt = (phase_inc >= {1'b0, q_eff}) ? '0 : phase_inc[15:0];
              if (sched) begin
                if (ring_n == '0) begin
                  got_nxt   = 1'b0;
                  state_nxt = ST_FIN;
                end else begin
                  state_nxt = ST_NORM;
                end
              end
            end
            CMD_URGENT: begin
              if ({1'b0, in_slot} < ring_n && !(cur_valid_r && cur_r == in_slot)
                  && !urgent_w[in_slot]) begin
                ctl.urg_set = 1'b1;
                pending_nxt = pending_r + CNT_W'(1);
              end
            end
            CMD_RUN: begin
              ctl.run_we  = 1'b1;
              ctl.run_val = in_running;
            end
            default: ;
          endcase
        end
      end
      ST_NORM: begin
        // take ring_head modulo the ring length, one subtract per cycle
        if ({1'b0, head_r} >= ring_n) begin
          head_nxt = SLOT_W'({1'b0, head_r} - ring_n);
        end else begin
          pos_nxt   = '0;
          found_nxt = 1'b0;
          low_nxt   = CREDIT_NEVER;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (run_w[s_idx] && urgent_w[s_idx]) begin
          ctl.urg_clr = 1'b1;
          ctl.tgt     = s_idx;
          if (pending_r != '0) pending_nxt = pending_r - CNT_W'(1);
          head_nxt  = s_inc[SLOT_W-1:0];
          win_nxt   = s_idx;
          got_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          if (take) begin
            low_nxt   = credit_w[s_idx];
            best_nxt  = s_idx;
            found_nxt = 1'b1;
          end
          pos_nxt = pos_r + SLOT_W'(1);
          if ({1'b0, pos_r} + CNT_W'(1) == ring_n) begin
            if (found_r || take) begin
              state_nxt = ST_APPLY;
            end else begin
              got_nxt   = 1'b0;
              state_nxt = ST_FIN;
            end
          end
        end
      end
      ST_APPLY: begin
        // broadcast: winner reloads, other running ring slots lose its credit
        ctl.apply = 1'b1;
        win_nxt   = best_r;
        got_nxt   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        sw_nxt        = (got_r != cur_valid_r) || (got_r && win_r != cur_r);
        cur_valid_nxt = got_r;
        cur_nxt       = got_r ? win_r : '0;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      phase_r     <= '0;
      pending_r   <= '0;
      cur_valid_r <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_r       <= cur_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // scan scratch and result payload need no reset
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    got_r   <= got_nxt;
    win_r   <= win_nxt;
    found_r <= found_nxt;
    low_r   <= low_nxt;
    best_r  <= best_nxt;
    sw_r    <= sw_nxt;
    if (out_load) begin
      o_slot_r  <= cur_r;
      o_valid_r <= cur_valid_r;
      o_sw_r    <= sw_r;
      o_pend_r  <= pending_r;
      o_runs_r  <= cur_valid_r ? count_w[cur_r] : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_executing_slot  = o_slot_r;
  assign out_executing_valid = o_valid_r;
  assign out_switched        = o_sw_r;
  assign out_pending_count   = o_pend_r;
  assign out_selected_runs   = o_runs_r;

  a_pending_bound : assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= CNT_W'(NSLOT))
    else $error("pending count above slot count");
  a_scan_in_ring : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ({1'b0, pos_r} < ring_n && {1'b0, head_r} < ring_n))
    else $error("scan position outside ring");
  a_done_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> (state_r == ST_DONE))
    else $error("result dropped while output stalled");
  a_idle_sel : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && got_r) |-> run_w[win_r] || !urgent_w[win_r])
    else $error("winner inconsistent");
endmodule
`default_nettype wire
